FILE: rtl/fcsg_pkg.sv
package fcsg_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int DIM_W  = 13;
    localparam int KEY_W  = 32;
    localparam int CTR_W  = 16;
    localparam int RAD_W  = 16;
    localparam int COL_W  = 32;
    localparam int STEP_W = 17;
    localparam int DEC_W  = 20;
    localparam int POS_W  = 19;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd768;
    localparam logic [KEY_W-1:0] TRANSPARENT_KEY_RST = '0;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH    = 2'd0,
        REG_SCREEN_HEIGHT   = 2'd1,
        REG_TRANSPARENT_KEY = 2'd2
    } t_reg_idx;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        SPAN_ROW_POS_Y = 2'd0,
        SPAN_ROW_NEG_Y = 2'd1,
        SPAN_ROW_POS_X = 2'd2,
        SPAN_ROW_NEG_X = 2'd3
    } t_span_sel;

endpackage

FILE: rtl/fcsg_span_clip.sv
module fcsg_span_clip #(
    parameter int COORD_BITS = fcsg_pkg::COORD_BITS_DEF
) (
    input  logic signed [fcsg_pkg::POS_W-1:0] i_row,
    input  logic signed [fcsg_pkg::POS_W-1:0] i_left,
    input  logic signed [fcsg_pkg::POS_W-1:0] i_right,
    input  logic        [fcsg_pkg::DIM_W-1:0] i_width,
    input  logic        [fcsg_pkg::DIM_W-1:0] i_height,
    input  logic        [fcsg_pkg::COL_W-1:0] i_color,
    input  logic        [fcsg_pkg::KEY_W-1:0] i_key,
    output logic        [COORD_BITS-1:0]      o_row,
    output logic        [COORD_BITS-1:0]      o_first,
    output logic        [COORD_BITS-1:0]      o_final,
    output logic                              o_visible
);

    localparam int PW = fcsg_pkg::POS_W;
    localparam logic signed [PW-1:0] LIM = PW'(1) << COORD_BITS;
    localparam logic signed [PW-1:0] ONE = PW'(1);

    logic signed [PW-1:0] w_ext;
    logic signed [PW-1:0] h_ext;
    logic signed [PW-1:0] w_eff;
    logic signed [PW-1:0] h_eff;
    logic signed [PW-1:0] w_last;
    logic signed [PW-1:0] first;
    logic signed [PW-1:0] final_col;
    logic                 vis;

    always_comb begin
        w_ext = $signed(PW'(i_width));
        h_ext = $signed(PW'(i_height));
        w_eff = (w_ext > LIM) ? LIM : w_ext;
        h_eff = (h_ext > LIM) ? LIM : h_ext;
        w_last = w_eff - ONE;
        first = (i_left < 0) ? '0 : i_left;
        final_col = (i_right > w_last) ? w_last : i_right;
        vis = (i_row >= 0) && (i_row < h_eff) && (first <= final_col) && (i_color != i_key);
        o_visible = vis;
        o_row   = vis ? i_row[COORD_BITS-1:0]     : '0;
        o_first = vis ? first[COORD_BITS-1:0]     : '0;
        o_final = vis ? final_col[COORD_BITS-1:0] : '0;
    end

endmodule

FILE: rtl/filled_circle_span_generator.sv
// Filled circle span generator. A start item (tuser 0) loads center, radius and colour and
// gives no spans. Each step item (tuser 1) of an active circle gives four spans, one per cycle
// unless m_axis_tready holds the output, since the single result port carries one span at a time;
// the next item is taken in the cycle the fourth span moves into the output register.
// The midpoint state advances when the step item is accepted and each span is clipped against
// the screen size and colour key between the span register and the output register. tlast
// marks the final span of a circle; tuser on the output is the visible flag.
module filled_circle_span_generator #(
    parameter int COORD_BITS = fcsg_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fcsg_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [fcsg_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [fcsg_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // center_x, center_y, radius, fill_color
    input  logic [79:0]                           s_axis_tdata,
    // kind
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // span_row, span_first, span_final, span_color, zero fill
    output logic [((3*COORD_BITS+32+7)/8)*8-1:0]  m_axis_tdata,
    // visible
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast
);

    localparam int PW     = fcsg_pkg::POS_W;
    localparam int SW     = fcsg_pkg::STEP_W;
    localparam int DW     = fcsg_pkg::DEC_W;
    localparam int OUT_W  = 3*COORD_BITS + fcsg_pkg::COL_W;
    localparam int OUT_TW = ((OUT_W+7)/8)*8;

    // configuration
    logic [fcsg_pkg::DIM_W-1:0] r_width;
    logic [fcsg_pkg::DIM_W-1:0] r_height;
    logic [fcsg_pkg::KEY_W-1:0] r_key;
    logic                       cfg_wr;
    fcsg_pkg::t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = fcsg_pkg::t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (cfg_idx)
            fcsg_pkg::REG_SCREEN_WIDTH:    prdata = fcsg_pkg::CFG_DATA_W'(r_width);
            fcsg_pkg::REG_SCREEN_HEIGHT:   prdata = fcsg_pkg::CFG_DATA_W'(r_height);
            fcsg_pkg::REG_TRANSPARENT_KEY: prdata = r_key;
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= fcsg_pkg::SCREEN_WIDTH_RST;
            r_height <= fcsg_pkg::SCREEN_HEIGHT_RST;
            r_key    <= fcsg_pkg::TRANSPARENT_KEY_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                fcsg_pkg::REG_SCREEN_WIDTH:    r_width  <= pwdata[fcsg_pkg::DIM_W-1:0];
                fcsg_pkg::REG_SCREEN_HEIGHT:   r_height <= pwdata[fcsg_pkg::DIM_W-1:0];
                fcsg_pkg::REG_TRANSPARENT_KEY: r_key    <= pwdata;
                default: ;
            endcase
        end
    end

    // input fields
    logic [fcsg_pkg::CTR_W-1:0] in_cx;
    logic [fcsg_pkg::CTR_W-1:0] in_cy;
    logic [fcsg_pkg::RAD_W-1:0] in_rad;
    logic [fcsg_pkg::COL_W-1:0] in_col;
    fcsg_pkg::t_kind            in_kind;

    assign in_cx   = s_axis_tdata[15:0];
    assign in_cy   = s_axis_tdata[31:16];
    assign in_rad  = s_axis_tdata[47:32];
    assign in_col  = s_axis_tdata[79:48];
    assign in_kind = fcsg_pkg::t_kind'(s_axis_tuser);

    // midpoint state
    logic signed [SW-1:0]        r_step_x, n_step_x;
    logic signed [SW-1:0]        r_step_y, n_step_y;
    logic signed [DW-1:0]        r_dec, n_dec;
    logic [fcsg_pkg::CTR_W-1:0]  r_cx, n_cx;
    logic [fcsg_pkg::CTR_W-1:0]  r_cy, n_cy;
    logic [fcsg_pkg::COL_W-1:0]  r_col, n_col;
    logic                        r_active, n_active;

    // span job
    logic                        r_job_valid, n_job_valid;
    fcsg_pkg::t_span_sel         r_job_idx, n_job_idx;
    logic signed [SW-1:0]        r_job_x, n_job_x;
    logic signed [SW-1:0]        r_job_y, n_job_y;
    logic [fcsg_pkg::CTR_W-1:0]  r_job_cx, n_job_cx;
    logic [fcsg_pkg::CTR_W-1:0]  r_job_cy, n_job_cy;
    logic [fcsg_pkg::COL_W-1:0]  r_job_col, n_job_col;
    logic                        r_job_done, n_job_done;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0]       r_out_row, n_out_row;
    logic [COORD_BITS-1:0]       r_out_first, n_out_first;
    logic [COORD_BITS-1:0]       r_out_final, n_out_final;
    logic [fcsg_pkg::COL_W-1:0]  r_out_col, n_out_col;
    logic                        r_out_vis, n_out_vis;
    logic                        r_out_last, n_out_last;

    logic                        out_adv;
    logic                        job_finish;
    logic                        in_acc;
    logic signed [SW-1:0]        nx_y;
    logic signed [SW-1:0]        nx_x;
    logic signed [SW-1:0]        diff_xy;

    logic signed [PW-1:0]        span_row;
    logic signed [PW-1:0]        span_left;
    logic signed [PW-1:0]        span_right;
    logic signed [PW-1:0]        ex_cx, ex_cy, ex_x, ex_y;
    logic [COORD_BITS-1:0]       clip_row, clip_first, clip_final;
    logic                        clip_vis;

    assign out_adv       = !r_out_valid || m_axis_tready;
    assign job_finish    = r_job_valid && out_adv && (r_job_idx == fcsg_pkg::SPAN_ROW_NEG_X);
    assign s_axis_tready = !r_job_valid || job_finish;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // state advance on accept
    always_comb begin
        n_step_x = r_step_x;
        n_step_y = r_step_y;
        n_dec    = r_dec;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_col    = r_col;
        n_active = r_active;
        nx_y     = r_step_y;
        nx_x     = r_step_x + SW'(1);
        diff_xy  = r_step_x - r_step_y;
        if (in_acc && in_kind == fcsg_pkg::KIND_START) begin
            n_cx     = in_cx;
            n_cy     = in_cy;
            n_col    = in_col;
            n_step_x = '0;
            n_step_y = $signed(SW'(in_rad));
            n_dec    = $signed(DW'(3)) - $signed({3'b000, in_rad, 1'b0});
            n_active = 1'b1;
        end else if (in_acc && r_active) begin
            if (r_dec < 0) begin
                n_dec = r_dec + $signed({{(DW-SW-2){r_step_x[SW-1]}}, r_step_x, 2'b00})
                        + $signed(DW'(6));
            end else begin
                n_dec = r_dec + $signed({{(DW-SW-2){diff_xy[SW-1]}}, diff_xy, 2'b00})
                        + $signed(DW'(10));
                nx_y  = r_step_y - SW'(1);
            end
            n_step_x = nx_x;
            n_step_y = nx_y;
            if (nx_x > nx_y) begin
                n_active = 1'b0;
            end
        end
    end

    // span job control
    always_comb begin
        n_job_valid = r_job_valid;
        n_job_idx   = r_job_idx;
        n_job_x     = r_job_x;
        n_job_y     = r_job_y;
        n_job_cx    = r_job_cx;
        n_job_cy    = r_job_cy;
        n_job_col   = r_job_col;
        n_job_done  = r_job_done;
        if (r_job_valid && out_adv) begin
            if (r_job_idx == fcsg_pkg::SPAN_ROW_NEG_X) begin
                n_job_valid = 1'b0;
                n_job_idx   = fcsg_pkg::SPAN_ROW_POS_Y;
            end else begin
                n_job_idx = fcsg_pkg::t_span_sel'(r_job_idx + 2'd1);
            end
        end
        if (in_acc && in_kind == fcsg_pkg::KIND_STEP && r_active) begin
            n_job_valid = 1'b1;
            n_job_idx   = fcsg_pkg::SPAN_ROW_POS_Y;
            n_job_x     = r_step_x;
            n_job_y     = r_step_y;
            n_job_cx    = r_cx;
            n_job_cy    = r_cy;
            n_job_col   = r_col;
            n_job_done  = (nx_x > nx_y);
        end
    end

    // span selection
    always_comb begin
        ex_cx = $signed(PW'(r_job_cx));
        ex_cy = $signed(PW'(r_job_cy));
        ex_x  = $signed({{(PW-SW){r_job_x[SW-1]}}, r_job_x});
        ex_y  = $signed({{(PW-SW){r_job_y[SW-1]}}, r_job_y});
        case (r_job_idx)
            fcsg_pkg::SPAN_ROW_POS_Y: begin
                span_row   = ex_cy + ex_y;
                span_left  = ex_cx - ex_x;
                span_right = ex_cx + ex_x;
            end
            fcsg_pkg::SPAN_ROW_NEG_Y: begin
                span_row   = ex_cy - ex_y;
                span_left  = ex_cx - ex_x;
                span_right = ex_cx + ex_x;
            end
            fcsg_pkg::SPAN_ROW_POS_X: begin
                span_row   = ex_cy + ex_x;
                span_left  = ex_cx - ex_y;
                span_right = ex_cx + ex_y;
            end
            fcsg_pkg::SPAN_ROW_NEG_X: begin
                span_row   = ex_cy - ex_x;
                span_left  = ex_cx - ex_y;
                span_right = ex_cx + ex_y;
            end
            default: begin
                span_row   = '0;
                span_left  = '0;
                span_right = '0;
            end
        endcase
    end

    fcsg_span_clip #(
        .COORD_BITS (COORD_BITS)
    ) u_clip (
        .i_row     (span_row),
        .i_left    (span_left),
        .i_right   (span_right),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_color   (r_job_col),
        .i_key     (r_key),
        .o_row     (clip_row),
        .o_first   (clip_first),
        .o_final   (clip_final),
        .o_visible (clip_vis)
    );

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_row   = r_out_row;
        n_out_first = r_out_first;
        n_out_final = r_out_final;
        n_out_col   = r_out_col;
        n_out_vis   = r_out_vis;
        n_out_last  = r_out_last;
        if (out_adv) begin
            n_out_valid = r_job_valid;
            n_out_row   = clip_row;
            n_out_first = clip_first;
            n_out_final = clip_final;
            n_out_col   = r_job_col;
            n_out_vis   = clip_vis;
            n_out_last  = r_job_done && (r_job_idx == fcsg_pkg::SPAN_ROW_NEG_X);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x    <= '0;
            r_step_y    <= '0;
            r_dec       <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_col       <= '0;
            r_active    <= 1'b0;
            r_job_valid <= 1'b0;
            r_job_idx   <= fcsg_pkg::SPAN_ROW_POS_Y;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_out_vis   <= 1'b0;
        end else begin
            r_step_x    <= n_step_x;
            r_step_y    <= n_step_y;
            r_dec       <= n_dec;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_col       <= n_col;
            r_active    <= n_active;
            r_job_valid <= n_job_valid;
            r_job_idx   <= n_job_idx;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
            r_out_vis   <= n_out_vis;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job_x     <= n_job_x;
        r_job_y     <= n_job_y;
        r_job_cx    <= n_job_cx;
        r_job_cy    <= n_job_cy;
        r_job_col   <= n_job_col;
        r_job_done  <= n_job_done;
        r_out_row   <= n_out_row;
        r_out_first <= n_out_first;
        r_out_final <= n_out_final;
        r_out_col   <= n_out_col;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'({r_out_col, r_out_final, r_out_first, r_out_row});
    assign m_axis_tuser  = r_out_vis;
    assign m_axis_tlast  = r_out_last;

    a_active_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_step_x <= r_step_y))
        else $error("midpoint x passed y while circle active");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_job_valid |-> (r_job_idx == fcsg_pkg::SPAN_ROW_POS_Y))
        else $error("span index moved without a job");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_vis) |-> (r_out_row == '0 && r_out_first == '0
                                         && r_out_final == '0))
        else $error("invisible span carries coordinates");

    a_vis_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_vis) |-> (r_out_first <= r_out_final))
        else $error("visible span is empty");

endmodule

FILE: tb/filled_circle_span_generator_tb.sv
module filled_circle_span_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CTR_W           = fcsg_pkg::CTR_W;
    localparam int RAD_W           = fcsg_pkg::RAD_W;
    localparam int COL_W           = fcsg_pkg::COL_W;
    localparam int DIM_W           = fcsg_pkg::DIM_W;
    localparam int KEY_W           = fcsg_pkg::KEY_W;
    localparam int CFG_ADDR_W      = fcsg_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W      = fcsg_pkg::CFG_DATA_W;
    localparam int CB              = fcsg_pkg::COORD_BITS_DEF;
    localparam int SPAN_W          = ((3*CB+32+7)/8)*8;
    localparam int ITEM_W          = 2*CTR_W + RAD_W + COL_W;
    localparam int DIM_LIMIT       = 1 << CB;
    localparam int ITEMS_PER_PHASE = 36;
    localparam int NUM_PHASES      = 5;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 200000;
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 4'd12;

    typedef struct packed {
        logic [CB-1:0]    row;
        logic [CB-1:0]    first_col;
        logic [CB-1:0]    last_col;
        logic [COL_W-1:0] colour;
        logic             visible;
        logic             ends_circle;
    } t_span;

    class span_scoreboard;
        logic [DIM_W-1:0] width_px;
        logic [DIM_W-1:0] height_px;
        logic [KEY_W-1:0] key_colour;
        int               step_x;
        int               step_y;
        int               decision;
        logic [CTR_W-1:0] held_cx;
        logic [CTR_W-1:0] held_cy;
        logic [COL_W-1:0] held_colour;
        bit               active;
        t_span            expected_spans[$];
        int               errors;
        int               spans_checked;

        function new();
            width_px      = fcsg_pkg::SCREEN_WIDTH_RST;
            height_px     = fcsg_pkg::SCREEN_HEIGHT_RST;
            key_colour    = fcsg_pkg::TRANSPARENT_KEY_RST;
            step_x        = 0;
            step_y        = 0;
            decision      = 0;
            held_cx       = '0;
            held_cy       = '0;
            held_colour   = '0;
            active        = 1'b0;
            errors        = 0;
            spans_checked = 0;
        endfunction

        function void write_reg(int idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                int'(fcsg_pkg::REG_SCREEN_WIDTH):    width_px   = value[DIM_W-1:0];
                int'(fcsg_pkg::REG_SCREEN_HEIGHT):   height_px  = value[DIM_W-1:0];
                int'(fcsg_pkg::REG_TRANSPARENT_KEY): key_colour = value[KEY_W-1:0];
                default: ;
            endcase
        endfunction

        function int clamp_dim(logic [DIM_W-1:0] v);
            return (int'(v) > DIM_LIMIT) ? DIM_LIMIT : int'(v);
        endfunction

        function void add_span(int row, int left, int right, bit ends);
            int    w;
            int    h;
            int    first;
            int    fin;
            bit    vis;
            t_span s;
            w     = clamp_dim(width_px);
            h     = clamp_dim(height_px);
            first = (left < 0) ? 0 : left;
            fin   = (right > w - 1) ? w - 1 : right;
            vis   = row >= 0 && row < h && first <= fin && held_colour != key_colour;
            s.row         = vis ? row[CB-1:0] : '0;
            s.first_col   = vis ? first[CB-1:0] : '0;
            s.last_col    = vis ? fin[CB-1:0] : '0;
            s.colour      = held_colour;
            s.visible     = vis;
            s.ends_circle = ends;
            expected_spans.push_back(s);
        endfunction

        function void note_item(fcsg_pkg::t_kind kind, logic [ITEM_W-1:0] data);
            int x;
            int y;
            int cx;
            int cy;
            bit done;
            if (kind == fcsg_pkg::KIND_START) begin
                held_cx     = data[CTR_W-1:0];
                held_cy     = data[2*CTR_W-1:CTR_W];
                step_x      = 0;
                step_y      = int'(data[2*CTR_W+RAD_W-1:2*CTR_W]);
                decision    = 3 - 2*step_y;
                held_colour = data[ITEM_W-1:2*CTR_W+RAD_W];
                active      = 1'b1;
                return;
            end
            if (!active)
                return;
            cx = int'(held_cx);
            cy = int'(held_cy);
            x  = step_x;
            y  = step_y;
            if (decision < 0) begin
                decision = decision + 4*x + 6;
            end else begin
                decision = decision + 4*(x - y) + 10;
                step_y   = y - 1;
            end
            step_x = x + 1;
            done   = step_x > step_y;
            if (done)
                active = 1'b0;
            add_span(cy + y, cx - x, cx + x, 1'b0);
            add_span(cy - y, cx - x, cx + x, 1'b0);
            add_span(cy + x, cx - y, cx + y, 1'b0);
            add_span(cy - x, cx - y, cx + y, done);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("tb: mismatch at %0t: %s", $time, what);
        endtask

        task check_span(logic [SPAN_W-1:0] data, logic vis, logic ends);
            t_span e;
            if (expected_spans.size() == 0) begin
                report_mismatch("span arrived with none expected");
                return;
            end
            e = expected_spans.pop_front();
            spans_checked++;
            if (data[CB-1:0] !== e.row)
                report_mismatch($sformatf("row %0d, want %0d", data[CB-1:0], e.row));
            if (data[2*CB-1:CB] !== e.first_col)
                report_mismatch($sformatf("first column %0d, want %0d",
                                          data[2*CB-1:CB], e.first_col));
            if (data[3*CB-1:2*CB] !== e.last_col)
                report_mismatch($sformatf("last column %0d, want %0d",
                                          data[3*CB-1:2*CB], e.last_col));
            if (data[3*CB+COL_W-1:3*CB] !== e.colour)
                report_mismatch($sformatf("colour %h, want %h",
                                          data[3*CB+COL_W-1:3*CB], e.colour));
            if (vis !== e.visible)
                report_mismatch($sformatf("visible %b, want %b", vis, e.visible));
            if (ends !== e.ends_circle)
                report_mismatch($sformatf("tlast %b, want %b", ends, e.ends_circle));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [ITEM_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SPAN_W-1:0]     m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    span_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int cycle_count = 0;

    filled_circle_span_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_span(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    task automatic send_item(fcsg_pkg::t_kind kind, logic [ITEM_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(kind, data);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_step();
        send_item(fcsg_pkg::KIND_STEP, {$urandom, $urandom, 16'($urandom)});
    endtask

    // start a circle and step it until it ends or max_steps is reached
    task automatic draw_circle(logic [CTR_W-1:0] cx, logic [CTR_W-1:0] cy,
                               logic [RAD_W-1:0] r, logic [COL_W-1:0] colour,
                               int max_steps);
        int n = 0;
        send_item(fcsg_pkg::KIND_START, {colour, r, cy, cx});
        while (sb.active && n < max_steps) begin
            send_step();
            n++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_spans.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(int'(addr >> 2), value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_screen(int w, int h, logic [KEY_W-1:0] key);
        apb_write({fcsg_pkg::REG_SCREEN_WIDTH, 2'b00}, w);
        apb_write({fcsg_pkg::REG_SCREEN_HEIGHT, 2'b00}, h);
        apb_write({fcsg_pkg::REG_TRANSPARENT_KEY, 2'b00}, key);
    endtask

    task automatic random_circle();
        logic [CTR_W-1:0] cx;
        logic [CTR_W-1:0] cy;
        logic [RAD_W-1:0] r;
        logic [COL_W-1:0] colour;
        int               max_steps;
        int               pick;
        pick      = $urandom_range(99);
        cx        = CTR_W'($urandom_range(0, 1100));
        cy        = CTR_W'($urandom_range(0, 1100));
        r         = RAD_W'($urandom_range(0, 12));
        colour    = ($urandom_range(99) < 15) ? sb.key_colour : $urandom;
        max_steps = 1000;
        if (pick < 10) begin
            cx = CTR_W'($urandom);
            cy = CTR_W'($urandom);
        end else if (pick < 18) begin
            // huge radius, dropped after a few steps
            r         = RAD_W'($urandom);
            max_steps = $urandom_range(1, 4);
        end else if (pick < 28) begin
            max_steps = $urandom_range(0, 3);
        end else if (pick < 36) begin
            send_step();
            return;
        end
        draw_circle(cx, cy, r, colour, max_steps);
    endtask

    initial begin
        int target;
        bit paused;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part on reset settings
        send_step();
        draw_circle(16'd100, 16'd50, 16'd0, 32'h1234_5678, 1000);
        send_step();
        draw_circle(16'd0, 16'd0, 16'd3, 32'hFFFF_FFFF, 1000);
        draw_circle(16'd1023, 16'd767, 16'd5, 32'hA5A5_A5A5, 2);
        draw_circle(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 2);
        draw_circle(16'd512, 16'd384, 16'd4, 32'h0000_0001, 1000);
        send_step();

        paused = 1'b0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin
                    set_screen(DIM_LIMIT, DIM_LIMIT, $urandom);
                    send_idle_pct  = 48;
                    recv_stall_pct = 0;
                end
                1: begin
                    set_screen(1, 8191, 32'hFFFF_FFFF);
                    send_idle_pct  = 0;
                    recv_stall_pct = 48;
                end
                2: begin
                    set_screen($urandom_range(1, DIM_LIMIT), $urandom_range(1, DIM_LIMIT),
                               $urandom);
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
                3: begin
                    set_screen(0, 0, 32'h0000_0000);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                default: begin
                    apb_write(UNMAPPED_ADDR, $urandom);
                    set_screen(1024, 768, $urandom);
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                random_circle();
                if (p == 2 && !paused && items_sent >= target - ITEMS_PER_PHASE/2) begin
                    // hold off until every pending span is out
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        $display("tb: %0d items sent, %0d spans checked", items_sent, sb.spans_checked);
        $display("tb: screens from zero to oversized, keyed colours, dropped circles");
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: timeout after %0d cycles", cycle_count);
        $display("tb: failure");
        $finish;
    end

endmodule
